>>> rtl/lusp_pkg.sv
// Package: shared types and constants for the lexical unit stream parser.
`timescale 1ns / 1ps
package lusp_pkg;

    localparam int MaxForm = 64;
    localparam int FormAw  = $clog2(MaxForm);
    localparam int FormLw  = $clog2(MaxForm + 1);

    typedef enum logic [3:0] {
        MK_NONE   = 4'd0,
        MK_OPEN   = 4'd1,
        MK_CLOSE  = 4'd2,
        MK_CARET  = 4'd3,
        MK_SLASH  = 4'd4,
        MK_LT     = 4'd5,
        MK_GT     = 4'd6,
        MK_STAR   = 4'd7,
        MK_HASH   = 4'd8,
        MK_PLUS   = 4'd9,
        MK_DOLLAR = 4'd10
    } t_marker;

    typedef enum logic [3:0] {
        CL_DROP    = 4'd0,
        CL_ESCAPE  = 4'd1,
        CL_BRACKET = 4'd2,
        CL_CARET   = 4'd3,
        CL_SLASH   = 4'd4,
        CL_LT      = 4'd5,
        CL_GT      = 4'd6,
        CL_STAR    = 4'd7,
        CL_HASH    = 4'd8,
        CL_PLUS    = 4'd9,
        CL_DOLLAR  = 4'd10,
        CL_NEWLINE = 4'd11,
        CL_SURFACE = 4'd12,
        CL_LEMMA   = 4'd13,
        CL_TAG     = 4'd14,
        CL_UNKNOWN = 4'd15
    } t_class;

    typedef enum logic [2:0] {
        ER_NONE     = 3'd0,
        ER_MISPLACE = 3'd1,
        ER_AFTER_GT = 3'd2,
        ER_BAD_END  = 3'd3,
        ER_MISMATCH = 3'd4,
        ER_OVERFLOW = 3'd5
    } t_error;

    // Character codes of the reserved markers
    localparam logic [20:0] CP_CARET  = 21'h5E;
    localparam logic [20:0] CP_DOLLAR = 21'h24;
    localparam logic [20:0] CP_LBRACK = 21'h5B;
    localparam logic [20:0] CP_RBRACK = 21'h5D;
    localparam logic [20:0] CP_SLASH  = 21'h2F;
    localparam logic [20:0] CP_LT     = 21'h3C;
    localparam logic [20:0] CP_GT     = 21'h3E;
    localparam logic [20:0] CP_STAR   = 21'h2A;
    localparam logic [20:0] CP_HASH   = 21'h23;
    localparam logic [20:0] CP_PLUS   = 21'h2B;
    localparam logic [20:0] CP_BSLASH = 21'h5C;
    localparam logic [20:0] CP_NL     = 21'h0A;

    // Item kind decided by the front end (K_END_ESC: end mark with escape pending)
    typedef enum logic [3:0] {
        K_END, K_ORD, K_ESC, K_OPEN, K_CLOSE, K_CARET, K_SLASH, K_STAR,
        K_LT, K_GT, K_HASH, K_PLUS, K_DOLLAR, K_NL, K_END_ESC
    } t_kind;

    // One classified item in the queue
    typedef struct packed {
        t_kind       kind;
        logic [20:0] cp;
    } t_item;

endpackage

>>> rtl/lusp_front.sv
// Front end: accepts items, tracks the escape bit and classifies them.
`timescale 1ns / 1ps
module lusp_front
    import lusp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [20:0] i_code_point,
    input  logic        i_end_of_input,
    output logic        o_valid,
    input  logic        i_ready,
    output t_item       o_item
);

    logic  r_esc, n_esc;
    logic  r_vld;
    t_item r_item, n_item;

    assign o_ready = !r_vld || i_ready;
    assign o_valid = r_vld;
    assign o_item  = r_item;

    // Classify by character unless an escape is pending
    always_comb begin
        n_item.cp = i_code_point;
        n_esc     = 1'b0;
        if (i_end_of_input) begin
            n_item.kind = r_esc ? K_END_ESC : K_END;
        end else if (r_esc) begin
            n_item.kind = K_ORD;
        end else begin
            case (i_code_point)
                CP_BSLASH: begin
                    n_item.kind = K_ESC;
                    n_esc = 1'b1;
                end
                CP_LBRACK: n_item.kind = K_OPEN;
                CP_RBRACK: n_item.kind = K_CLOSE;
                CP_CARET:  n_item.kind = K_CARET;
                CP_SLASH:  n_item.kind = K_SLASH;
                CP_STAR:   n_item.kind = K_STAR;
                CP_LT:     n_item.kind = K_LT;
                CP_GT:     n_item.kind = K_GT;
                CP_HASH:   n_item.kind = K_HASH;
                CP_PLUS:   n_item.kind = K_PLUS;
                CP_DOLLAR: n_item.kind = K_DOLLAR;
                CP_NL:     n_item.kind = K_NL;
                default:   n_item.kind = K_ORD;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc <= 1'b0;
            r_vld <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                r_esc <= n_esc;
                r_vld <= 1'b1;
            end else if (i_ready) begin
                r_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= n_item;
        end
    end

endmodule

>>> rtl/lusp_fifo.sv
// Two-entry queue between front and back end.
`timescale 1ns / 1ps
module lusp_fifo
    import lusp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_ready,
    output t_item o_item
);

    t_item       r_mem [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic        w_push, w_pop;

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_item  = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= !r_wp;
            if (w_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

>>> rtl/lusp_back.sv
// Back end: marker state machine, surface store, counters and result register.
`timescale 1ns / 1ps
module lusp_back
    import lusp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_item       i_item,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_char_class,
    output logic [2:0]  o_error_code,
    output logic [15:0] o_line_number,
    output logic [15:0] o_column
);

    t_marker           r_mk, n_mk;
    logic              r_imm, n_imm;
    logic              r_open, n_open;
    t_error            r_err, n_err;
    logic [FormLw-1:0] r_slen, n_slen;
    logic [FormLw-1:0] r_cidx, n_cidx;
    logic              r_mis, n_mis;
    logic [15:0]       r_line, n_line;
    logic [15:0]       r_col, n_col;
    logic [20:0]       r_store [MaxForm];
    logic [20:0]       r_rd;
    logic              r_vld;
    t_class            r_cls, n_cls;
    logic              w_fire, w_wr;
    logic              w_gap;

    assign o_ready = !r_vld || i_ready;
    assign w_fire  = i_valid && o_ready;
    assign w_gap   = r_mk == MK_NONE || r_mk == MK_CLOSE || r_mk == MK_DOLLAR;

    always_comb begin
        n_mk = r_mk; n_imm = r_imm; n_open = r_open; n_err = r_err;
        n_slen = r_slen; n_cidx = r_cidx; n_mis = r_mis;
        n_line = r_line; n_col = r_col; n_cls = CL_DROP; w_wr = 1'b0;
        if (i_item.kind != K_END && i_item.kind != K_END_ESC && r_col != 16'hFFFF)
            n_col = r_col + 16'd1;
        case (i_item.kind)
            K_END: begin
                if (!w_gap && r_err == ER_NONE) n_err = ER_BAD_END;
            end
            K_END_ESC: begin
                if (r_err == ER_NONE) n_err = ER_BAD_END;
            end
            K_ESC: n_cls = CL_ESCAPE;
            K_ORD: begin
                n_imm = 1'b0;
                case (r_mk)
                    MK_CARET: begin
                        n_cls = CL_SURFACE;
                        if (r_slen < FormLw'(MaxForm)) begin
                            w_wr = 1'b1;
                            n_slen = r_slen + FormLw'(1);
                        end else if (r_err == ER_NONE) begin
                            n_err = ER_OVERFLOW;
                        end
                    end
                    MK_SLASH, MK_HASH, MK_PLUS: n_cls = CL_LEMMA;
                    MK_STAR: begin
                        n_cls = CL_UNKNOWN;
                        if (!(r_cidx < r_slen && r_rd == i_item.cp)) n_mis = 1'b1;
                        if (r_cidx < FormLw'(MaxForm)) n_cidx = r_cidx + FormLw'(1);
                    end
                    MK_LT: n_cls = CL_TAG;
                    MK_GT: if (r_err == ER_NONE) n_err = ER_AFTER_GT;
                    default: n_cls = CL_DROP;
                endcase
            end
            K_OPEN: begin
                if (!w_gap && r_err == ER_NONE) n_err = ER_MISPLACE;
                n_mk = MK_OPEN; n_imm = 1'b1; n_cls = CL_BRACKET;
            end
            K_CLOSE: begin
                if (r_mk != MK_OPEN && r_err == ER_NONE) n_err = ER_MISPLACE;
                n_mk = MK_CLOSE; n_imm = 1'b1; n_cls = CL_BRACKET;
            end
            K_CARET: if (r_mk != MK_OPEN) begin
                if (!w_gap && r_err == ER_NONE) n_err = ER_MISPLACE;
                n_mk = MK_CARET; n_imm = 1'b1; n_cls = CL_CARET;
                n_slen = '0; n_cidx = '0; n_mis = 1'b0; n_open = 1'b0;
            end
            K_SLASH: if (r_mk != MK_OPEN) begin
                if (!((r_mk == MK_CARET && !r_imm) || (r_mk == MK_GT && r_imm) ||
                      (r_mk == MK_HASH && !r_imm)) && r_err == ER_NONE)
                    n_err = ER_MISPLACE;
                n_open = 1'b1; n_mk = MK_SLASH; n_imm = 1'b1; n_cls = CL_SLASH;
            end
            K_STAR: if (!w_gap && r_mk != MK_OPEN) begin
                if (!(r_mk == MK_SLASH && r_imm) && r_err == ER_NONE) n_err = ER_MISPLACE;
                n_cidx = '0; n_mis = 1'b0;
                n_mk = MK_STAR; n_imm = 1'b1; n_cls = CL_STAR;
            end
            K_LT: if (r_mk != MK_OPEN) begin
                if (!((r_mk == MK_SLASH && !r_imm) || (r_mk == MK_GT && r_imm) ||
                      (r_mk == MK_PLUS && !r_imm)) && r_err == ER_NONE)
                    n_err = ER_MISPLACE;
                n_mk = MK_LT; n_imm = 1'b1; n_cls = CL_LT;
            end
            K_GT: if (r_mk != MK_OPEN) begin
                if (!(r_mk == MK_LT && !r_imm) && r_err == ER_NONE) n_err = ER_MISPLACE;
                n_mk = MK_GT; n_imm = 1'b1; n_cls = CL_GT;
            end
            K_HASH: if (!w_gap && r_mk != MK_OPEN) begin
                if (!(r_mk == MK_GT && r_imm) && r_err == ER_NONE) n_err = ER_MISPLACE;
                n_mk = MK_HASH; n_imm = 1'b1; n_cls = CL_HASH;
            end
            K_PLUS: if (!w_gap && r_mk != MK_OPEN) begin
                if (((r_mk == MK_GT && !r_imm) || (r_mk == MK_HASH && r_imm) || !r_open)
                    && r_err == ER_NONE) n_err = ER_MISPLACE;
                n_mk = MK_PLUS; n_imm = 1'b1; n_cls = CL_PLUS;
            end
            K_DOLLAR: if (r_mk != MK_OPEN) begin
                if (r_err == ER_NONE) begin
                    if (r_mk == MK_STAR) begin
                        if (r_imm) n_err = ER_MISPLACE;
                        else if (r_mis || r_cidx != r_slen) n_err = ER_MISMATCH;
                    end else if (!((r_mk == MK_GT && r_imm) || (r_mk == MK_HASH && !r_imm))) begin
                        n_err = ER_MISPLACE;
                    end
                end
                n_mk = MK_DOLLAR; n_imm = 1'b1; n_cls = CL_DOLLAR;
            end
            K_NL: begin
                if (r_mk != MK_OPEN && r_err == ER_NONE) n_err = ER_MISPLACE;
                if (r_line != 16'hFFFF) n_line = r_line + 16'd1;
                n_col = '0; n_cls = CL_NEWLINE;
            end
            default: n_cls = CL_DROP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mk <= MK_NONE; r_imm <= 1'b0; r_open <= 1'b0; r_err <= ER_NONE;
            r_slen <= '0; r_cidx <= '0; r_mis <= 1'b0;
            r_line <= 16'd1; r_col <= '0; r_vld <= 1'b0; r_cls <= CL_DROP;
        end else begin
            if (w_fire) begin
                r_mk <= n_mk; r_imm <= n_imm; r_open <= n_open; r_err <= n_err;
                r_slen <= n_slen; r_cidx <= n_cidx; r_mis <= n_mis;
                r_line <= n_line; r_col <= n_col; r_cls <= n_cls;
                r_vld <= 1'b1;
            end else if (i_ready) begin
                r_vld <= 1'b0;
            end
        end
    end

    // Surface store; the compare entry is fetched one transfer ahead
    always_ff @(posedge i_clk) begin
        if (w_fire && w_wr) begin
            r_store[r_slen[FormAw-1:0]] <= i_item.cp;
        end
        if (w_fire) begin
            r_rd <= r_store[n_cidx[FormAw-1:0]];
        end
    end

    assign o_valid       = r_vld;
    assign o_char_class  = r_cls;
    assign o_error_code  = r_err;
    assign o_line_number = r_line;
    assign o_column      = r_col;

endmodule

>>> rtl/lexical_unit_stream_parser_top.sv
// Top level of the lexical unit stream parser.
`timescale 1ns / 1ps
// Lexical unit stream parser.
// Input channel: i_valid/o_ready carry one code point (i_code_point) or an
// end-of-input mark (i_end_of_input) per transfer.
// Output channel: o_valid/i_ready carry one result per input item: class,
// sticky error code, line number and column after that item.
// Path: front register (classify, escape), two-entry queue, back end
// (marker state, surface store, counters) with its output register.
// Throughput: one item per cycle while the receiver holds i_ready; the surface
// store takes one write and one read a cycle, and the marker state updates once per item.
// Reset (synchronous, active low) clears the marker state, counters (line
// starts at 1) and error; the surface store holds no reset value.
// When the receiver stalls, results back up into the queue and the front
// register, then o_ready drops; nothing is lost or repeated.
module lexical_unit_stream_parser_top
    import lusp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [20:0] i_code_point,
    input  logic        i_end_of_input,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_char_class,
    output logic [2:0]  o_error_code,
    output logic [15:0] o_line_number,
    output logic [15:0] o_column
);

    logic  w_fv, w_fr, w_qv, w_qr;
    t_item w_fi, w_qi;

    lusp_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_code_point, .i_end_of_input,
        .o_valid(w_fv), .i_ready(w_fr), .o_item(w_fi)
    );

    lusp_fifo u_fifo (
        .i_clk, .i_rst_n, .i_valid(w_fv), .o_ready(w_fr), .i_item(w_fi),
        .o_valid(w_qv), .i_ready(w_qr), .o_item(w_qi)
    );

    lusp_back u_back (
        .i_clk, .i_rst_n, .i_valid(w_qv), .o_ready(w_qr), .i_item(w_qi),
        .o_valid, .i_ready, .o_char_class, .o_error_code, .o_line_number, .o_column
    );

    // Errors are sticky once set, until reset
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(o_error_code) != ER_NONE |-> o_error_code == $past(o_error_code))
        else $error("error code changed after latching");

    // Line number is never zero out of reset
    a_line_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_line_number != 16'd0)
        else $error("line number zero");

    // Newline result resets the column
    a_nl_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_char_class == CL_NEWLINE |-> o_column == 16'd0)
        else $error("column not cleared on newline");

endmodule
